// ----- rtl/core/mtfp_pkg.sv -----
// Package: item types and phase codes for the frame parser.
`timescale 1ns / 1ps

package mtfp_pkg;

	localparam logic [7:0] START_BYTE = 8'hFE;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       buffer_end;
	} in_item_t;

	typedef struct packed {
		logic       is_frame_end;
		logic [7:0] payload_byte;
		logic [7:0] payload_index;
		logic [7:0] command_high;
		logic [7:0] command_low;
		logic [7:0] payload_length;
		logic       check_ok;
	} out_item_t;

	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_LEN  = 3'd1,
		PH_CMD1 = 3'd2,
		PH_CMD2 = 3'd3,
		PH_DATA = 3'd4,
		PH_FCS  = 3'd5
	} phase_t;

endpackage

// ----- rtl/core/mtfp_stream_if.sv -----
// Interface: valid/ready stream channel with a typed payload.
`timescale 1ns / 1ps

interface mtfp_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/mtfp_parse.sv -----
// Frame parser state machine: frame registers and per-item record generation.
`timescale 1ns / 1ps

module mtfp_parse (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  mtfp_pkg::in_item_t item,
	output logic               res_valid,
	output mtfp_pkg::out_item_t res
);
	import mtfp_pkg::*;

	phase_t     phase_q, phase_d;
	logic [7:0] len_q, cmd_hi_q, cmd_lo_q, seen_q, xor_q;
	logic [7:0] seen_inc;

	assign seen_inc = seen_q + 8'd1;

	// next state
	always_comb begin
		phase_d = PH_HUNT;
		unique case (phase_q)
			PH_LEN:  phase_d = PH_CMD1;
			PH_CMD1: phase_d = PH_CMD2;
			PH_CMD2: phase_d = (len_q != 8'd0) ? PH_DATA : PH_FCS;
			PH_DATA: phase_d = (seen_inc == len_q) ? PH_FCS : PH_DATA;
			PH_FCS:  phase_d = PH_HUNT;
			default: phase_d = (item.rx_byte == START_BYTE) ? PH_LEN : PH_HUNT;
		endcase
		// buffer end drops any partial frame
		if (item.buffer_end)
			phase_d = PH_HUNT;
	end

	// outputs
	always_comb begin
		res_valid          = 1'b0;
		res.is_frame_end   = 1'b0;
		res.payload_byte   = 8'd0;
		res.payload_index  = 8'd0;
		res.command_high   = cmd_hi_q;
		res.command_low    = cmd_lo_q;
		res.payload_length = len_q;
		res.check_ok       = 1'b0;
		unique case (phase_q)
			PH_DATA: begin
				res_valid         = 1'b1;
				res.payload_byte  = item.rx_byte;
				res.payload_index = seen_q;
			end
			PH_FCS: begin
				res_valid        = 1'b1;
				res.is_frame_end = 1'b1;
				res.check_ok     = (xor_q == item.rx_byte);
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			len_q    <= 8'd0;
			cmd_hi_q <= 8'd0;
			cmd_lo_q <= 8'd0;
			seen_q   <= 8'd0;
			xor_q    <= 8'd0;
		end else if (step) begin
			phase_q <= phase_d;
			case (phase_q)
				PH_LEN: begin
					len_q  <= item.rx_byte;
					xor_q  <= item.rx_byte;
					seen_q <= 8'd0;
				end
				PH_CMD1: begin
					cmd_hi_q <= item.rx_byte;
					xor_q    <= xor_q ^ item.rx_byte;
				end
				PH_CMD2: begin
					cmd_lo_q <= item.rx_byte;
					xor_q    <= xor_q ^ item.rx_byte;
				end
				PH_DATA: begin
					xor_q  <= xor_q ^ item.rx_byte;
					seen_q <= seen_inc;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/mt_uart_frame_parser.sv -----
// Top level: byte-stream frame parser with input and result registers.
//
//   channel  dir  payload                                          type
//   stream   in   rx_byte, buffer_end                              mtfp_pkg::in_item_t
//   record   out  is_frame_end, payload_byte, payload_index,       mtfp_pkg::out_item_t
//                 command_high, command_low, payload_length, check_ok
//
// One byte per cycle sustained while records are taken. A byte sits in the
// input register, where the parser state machine handles it, and its record
// (if any) appears from the result register the cycle after. Reset puts the
// parser in the start byte hunt with all frame registers cleared. A stalled
// record holds the pipe only once both registers are full.
`timescale 1ns / 1ps

module mt_uart_frame_parser (
	input  logic         clk,
	input  logic         arst_n,
	mtfp_stream_if.sink  stream,
	mtfp_stream_if.source record
);
	import mtfp_pkg::*;

	logic      valid_s1;
	in_item_t  item_s1;
	logic      rec_valid_q;
	out_item_t rec_q;
	logic      out_free, advance;
	logic      res_valid;
	out_item_t res;

	assign out_free     = !rec_valid_q || record.ready;
	assign advance      = valid_s1 && out_free;
	assign stream.ready = !valid_s1 || out_free;
	assign record.valid = rec_valid_q;
	assign record.data  = rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready)
			item_s1 <= stream.data;
	end

	mtfp_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid_q <= 1'b0;
		end else if (out_free) begin
			rec_valid_q <= advance && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid)
			rec_q <= res;
	end

	a_end_rec_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid_q && rec_q.is_frame_end |->
			rec_q.payload_byte == 8'd0 && rec_q.payload_index == 8'd0)
		else $error("end record carries payload fields");

	a_data_rec_no_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid_q && !rec_q.is_frame_end |-> !rec_q.check_ok)
		else $error("payload record flags check_ok");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("stalled input register lost its item");

	a_rec_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |-> rec_valid_q && !record.ready)
		else $error("input register stalled without a blocked record");

endmodule

// ----- tb/sv/mtfp_record_checker.sv -----
// Checker: predicts frame parser records from accepted bytes and compares them.
`timescale 1ns / 1ps

module mtfp_record_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	input  logic                byte_ready,
	input  mtfp_pkg::in_item_t  byte_data,
	input  logic                rec_valid,
	input  logic                rec_ready,
	input  mtfp_pkg::out_item_t rec_data,
	output int                  errors,
	output int                  pending
);
	import mtfp_pkg::*;

	phase_t     parse_phase;
	logic [7:0] frame_len;
	logic [7:0] cmd_hi;
	logic [7:0] cmd_lo;
	logic [7:0] data_count;
	logic [7:0] xor_acc;
	out_item_t  expected_records[$];

	function automatic int field_diff(input string name, input logic [7:0] exp_v,
			input logic [7:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, exp_v, act_v);
			return 1;
		end
		return 0;
	endfunction

	task automatic parse_byte(input in_item_t item);
		out_item_t rec;
		logic [7:0] b;
		b = item.rx_byte;
		rec = '0;
		rec.command_high = cmd_hi;
		rec.command_low = cmd_lo;
		rec.payload_length = frame_len;
		case (parse_phase)
			PH_LEN: begin
				frame_len = b;
				xor_acc = b;
				data_count = '0;
				parse_phase = PH_CMD1;
			end
			PH_CMD1: begin
				cmd_hi = b;
				xor_acc ^= b;
				parse_phase = PH_CMD2;
			end
			PH_CMD2: begin
				cmd_lo = b;
				xor_acc ^= b;
				parse_phase = (frame_len != 8'd0) ? PH_DATA : PH_FCS;
			end
			PH_DATA: begin
				rec.payload_byte = b;
				rec.payload_index = data_count;
				expected_records.push_back(rec);
				xor_acc ^= b;
				data_count = data_count + 8'd1;
				if (data_count == frame_len)
					parse_phase = PH_FCS;
			end
			PH_FCS: begin
				rec.is_frame_end = 1'b1;
				rec.check_ok = (xor_acc == b);
				expected_records.push_back(rec);
				parse_phase = PH_HUNT;
			end
			default: begin
				parse_phase = (b == START_BYTE) ? PH_LEN : PH_HUNT;
			end
		endcase
		// buffer end drops whatever frame is in progress
		if (item.buffer_end)
			parse_phase = PH_HUNT;
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_rec;
		if (!arst_n) begin
			parse_phase = PH_HUNT;
			frame_len = '0;
			cmd_hi = '0;
			cmd_lo = '0;
			data_count = '0;
			xor_acc = '0;
			expected_records.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (rec_valid && rec_ready) begin
				if (expected_records.size() == 0) begin
					$display("%0t: record expected none, got %h", $time, rec_data);
					errors++;
				end else begin
					exp_rec = expected_records.pop_front();
					errors += field_diff("is_frame_end", 8'(exp_rec.is_frame_end),
						8'(rec_data.is_frame_end));
					errors += field_diff("payload_byte", exp_rec.payload_byte,
						rec_data.payload_byte);
					errors += field_diff("payload_index", exp_rec.payload_index,
						rec_data.payload_index);
					errors += field_diff("command_high", exp_rec.command_high,
						rec_data.command_high);
					errors += field_diff("command_low", exp_rec.command_low,
						rec_data.command_low);
					errors += field_diff("payload_length", exp_rec.payload_length,
						rec_data.payload_length);
					errors += field_diff("check_ok", 8'(exp_rec.check_ok),
						8'(rec_data.check_ok));
				end
			end
			if (byte_valid && byte_ready)
				parse_byte(byte_data);
			pending = expected_records.size();
		end
	end

endmodule

// ----- tb/sv/tb_mt_uart_frame_parser.sv -----
// Testbench top: byte stimulus, record back-pressure and verdict for the frame parser.
`timescale 1ns / 1ps

module tb_mt_uart_frame_parser;
	import mtfp_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	int send_idle_pct = 29;
	int recv_idle_pct = 62;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int frame_items = 0;
	int errors;
	int pending;

	mtfp_stream_if #(.T(in_item_t))  byte_ch ();
	mtfp_stream_if #(.T(out_item_t)) record_ch ();

	mt_uart_frame_parser u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (byte_ch),
		.record (record_ch)
	);

	mtfp_record_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_ch.valid),
		.byte_ready (byte_ch.ready),
		.byte_data  (byte_ch.data),
		.rec_valid  (record_ch.valid),
		.rec_ready  (record_ch.ready),
		.rec_data   (record_ch.data),
		.errors     (errors),
		.pending    (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

	// record sink: random stalls, plus a long hold-off when requested
	initial begin
		record_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				record_ch.ready = 1'b0;
				hold_left--;
			end else begin
				record_ch.ready = ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic send_item(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			byte_ch.valid = 1'b0;
			@(negedge clk);
		end
		byte_ch.valid = 1'b1;
		byte_ch.data.rx_byte = b;
		byte_ch.data.buffer_end = last;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
		frame_items++;
		@(negedge clk);
	endtask

	// start byte, length, two commands, payload, check; cut >= 0 ends the buffer there
	task automatic send_frame(input int len, input bit corrupt, input int cut);
		logic [7:0] chk;
		logic [7:0] b;
		chk = '0;
		for (int pos = 0; pos <= len + 4; pos++) begin
			if (pos == 0)
				b = START_BYTE;
			else if (pos == 1)
				b = len[7:0];
			else if (pos < len + 4)
				b = ($urandom_range(9) == 0) ? START_BYTE : 8'($urandom);
			else
				b = corrupt ? 8'($urandom) : chk;
			if (pos > 0 && pos < len + 4)
				chk ^= b;
			send_item(b, pos == cut);
			if (pos == cut)
				break;
		end
	endtask

	task automatic random_traffic(input int target);
		int len;
		int cut;
		bit corrupt;
		while (frame_items < target) begin
			if ($urandom_range(99) < 25) begin
				send_item(($urandom_range(7) == 0) ? START_BYTE : 8'($urandom),
					$urandom_range(9) == 0);
			end else begin
				len = ($urandom_range(29) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
				corrupt = ($urandom_range(2) == 0);
				cut = -1;
				if ($urandom_range(5) == 0)
					cut = $urandom_range(0, len + 4);
				send_frame(len, corrupt, cut);
			end
		end
	endtask

	task automatic set_pressure(input int s_pct, input int r_pct, input bit hold);
		@(posedge clk);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		hold_req = hold;
		@(negedge clk);
	endtask

	initial begin
		byte_ch.valid = 1'b0;
		byte_ch.data = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// noise while hunting
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		// start byte with buffer end is dropped, next byte is still hunted
		send_item(START_BYTE, 1'b1);
		send_item(8'h01, 1'b0);
		// empty payload, good check
		send_item(START_BYTE, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		// start byte inside the payload, bad check
		send_item(START_BYTE, 1'b0);
		send_item(8'h02, 1'b0);
		send_item(8'h12, 1'b0);
		send_item(8'h34, 1'b0);
		send_item(START_BYTE, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h26, 1'b0);
		// buffer end on a payload byte: byte emitted, frame dropped
		send_item(START_BYTE, 1'b0);
		send_item(8'h03, 1'b0);
		send_item(8'hAA, 1'b0);
		send_item(8'h55, 1'b0);
		send_item(8'h01, 1'b1);
		send_item(8'h02, 1'b0);
		// buffer end on the check byte keeps the end record
		send_item(START_BYTE, 1'b0);
		send_item(8'h01, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'h80, 1'b0);
		send_item(8'h81, 1'b1);

		random_traffic(370);
		set_pressure(62, 29, 1'b0);
		random_traffic(740);
		// no idling; the sink holds off while a full-length frame streams in
		set_pressure(0, 0, 1'b1);
		send_frame(255, 1'b0, -1);
		random_traffic(1100);
		byte_ch.valid = 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/mtfp_pkg.sv
rtl/core/mtfp_stream_if.sv
rtl/core/mtfp_parse.sv
rtl/core/mt_uart_frame_parser.sv
tb/sv/mtfp_record_checker.sv
tb/sv/tb_mt_uart_frame_parser.sv
